[design/motor_command_frame_encoder_macros.svh]
// Assertion macros for the motor command frame encoder.
`ifndef MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MCFE_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mcfe: assertion failed");
// Next-cycle implication, checked out of reset.
`define MCFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mcfe: assertion failed");
`else
`define MCFE_ASSERT(label, ante, cons)
`define MCFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/mcfe_pkg.sv]
package mcfe_pkg;

   typedef enum logic [2:0] {
      ACT_DUTY    = 3'd0,
      ACT_CURRENT = 3'd1,
      ACT_BRAKE   = 3'd2,
      ACT_SPEED   = 3'd3,
      ACT_ANGLE   = 3'd4
   } action_type;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_START   = 3'd0;
   localparam logic [2:0] REG_STOP    = 3'd1;
   localparam logic [2:0] REG_DUTY    = 3'd2;
   localparam logic [2:0] REG_CURRENT = 3'd3;
   localparam logic [2:0] REG_BRAKE   = 3'd4;
   localparam logic [2:0] REG_SPEED   = 3'd5;
   localparam logic [2:0] REG_ANGLE   = 3'd6;

   // Byte positions inside a frame
   localparam logic [3:0] POS_START  = 4'd0;
   localparam logic [3:0] POS_LEN    = 4'd1;
   localparam logic [3:0] POS_ID     = 4'd2;
   localparam logic [3:0] POS_VAL3   = 4'd3;
   localparam logic [3:0] POS_VAL2   = 4'd4;
   localparam logic [3:0] POS_VAL1   = 4'd5;
   localparam logic [3:0] POS_VAL0   = 4'd6;
   localparam logic [3:0] POS_CRC_HI = 4'd7;
   localparam logic [3:0] POS_CRC_LO = 4'd8;
   localparam logic [3:0] POS_STOP   = 4'd9;

   localparam logic [7:0] FRAME_LEN = 8'd5;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic signed [31:0] DUTY_MAX    = 32'sd100000;
   localparam logic signed [31:0] DUTY_MIN    = -32'sd100000;
   localparam logic signed [31:0] CURRENT_MAX = 32'sd85000;
   localparam logic signed [31:0] CURRENT_MIN = -32'sd85000;
   localparam logic signed [31:0] ANGLE_MAX   = 32'sd360000000;
   localparam logic signed [31:0] ZERO_VALUE  = 32'sd0;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] stop_byte;
      logic [7:0] id_duty;
      logic [7:0] id_current;
      logic [7:0] id_brake;
      logic [7:0] id_speed;
      logic [7:0] id_angle;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_byte: 8'd2,
      stop_byte:  8'd3,
      id_duty:    8'd5,
      id_current: 8'd6,
      id_brake:   8'd7,
      id_speed:   8'd8,
      id_angle:   8'd9
   };

   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         id;
      logic               port;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] pos;
   } stat_type;

   function automatic logic signed [31:0] clamp_value(
      input logic signed [31:0] v,
      input logic signed [31:0] lo,
      input logic signed [31:0] hi
   );
      logic signed [31:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // One byte into CRC-16, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[design/mcfe_channels.sv]
interface mcfe_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [31:0] value;
   logic               motor;

   modport source (output valid, output action, output value, output motor, input ready);
   modport sink (input valid, input action, input value, input motor, output ready);
endinterface

interface mcfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_port;
   logic       last;

   modport source (output valid, output out_byte, output out_port, output last, input ready);
   modport sink (input valid, input out_byte, input out_port, input last, output ready);
endinterface

[design/mcfe_clamp.sv]
module mcfe_clamp (
   input  logic              clock,
   input  logic              reset,
   mcfe_req_if.sink          req,
   input  mcfe_pkg::cfg_type cfg,
   output mcfe_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready
);

   logic                 valid_ff;
   logic                 valid_in;
   mcfe_pkg::action_type action_ff;
   logic signed [31:0]   value_ff;
   logic                 motor_ff;
   logic                 known;
   logic signed [31:0]   clamped;
   logic [7:0]           id_sel;
   logic                 take;
   logic                 load;

   always_comb begin
      known   = 1'b1;
      clamped = value_ff;
      id_sel  = cfg.id_speed;
      unique case (action_ff)
         mcfe_pkg::ACT_DUTY: begin
            clamped = mcfe_pkg::clamp_value(value_ff, mcfe_pkg::DUTY_MIN, mcfe_pkg::DUTY_MAX);
            id_sel  = cfg.id_duty;
         end
         mcfe_pkg::ACT_CURRENT: begin
            clamped = mcfe_pkg::clamp_value(value_ff, mcfe_pkg::CURRENT_MIN,
                                            mcfe_pkg::CURRENT_MAX);
            id_sel  = cfg.id_current;
         end
         mcfe_pkg::ACT_BRAKE: begin
            clamped = mcfe_pkg::clamp_value(value_ff, mcfe_pkg::ZERO_VALUE,
                                            mcfe_pkg::CURRENT_MAX);
            id_sel  = cfg.id_brake;
         end
         mcfe_pkg::ACT_SPEED: begin
            id_sel  = cfg.id_speed;
         end
         mcfe_pkg::ACT_ANGLE: begin
            clamped = mcfe_pkg::clamp_value(value_ff, mcfe_pkg::ZERO_VALUE,
                                            mcfe_pkg::ANGLE_MAX);
            id_sel  = cfg.id_angle;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // drop unknown kinds without a frame
   assign take      = valid_ff && (!known || cmd_ready);
   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;
   assign cmd_valid = valid_ff && known;
   assign cmd.value = clamped;
   assign cmd.id    = id_sel;
   assign cmd.port  = motor_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= mcfe_pkg::action_type'(req.action);
         value_ff  <= req.value;
         motor_ff  <= req.motor;
      end
   end

endmodule

[design/mcfe_serializer.sv]
module mcfe_serializer (
   input  logic               clock,
   input  logic               reset,
   input  mcfe_pkg::cmd_type  cmd,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  mcfe_pkg::cfg_type  cfg,
   mcfe_rsp_if.source         rsp,
   output mcfe_pkg::stat_type stat
);

   logic              busy_ff;
   logic              busy_in;
   logic [3:0]        pos_ff;
   logic [3:0]        pos_in;
   mcfe_pkg::cmd_type frame_ff;
   logic [15:0]       crc_ff;
   logic [15:0]       crc_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [7:0]        out_byte_ff;
   logic              out_port_ff;
   logic              out_last_ff;
   logic [7:0]        cur_byte;
   logic              out_free;
   logic              advance;
   logic              at_end;
   logic              load;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = busy_ff && out_free;
   assign at_end    = (pos_ff == mcfe_pkg::POS_STOP);
   assign cmd_ready = !busy_ff || (advance && at_end);
   assign load      = cmd_valid && cmd_ready;

   always_comb begin
      unique case (pos_ff)
         mcfe_pkg::POS_START:  cur_byte = cfg.start_byte;
         mcfe_pkg::POS_LEN:    cur_byte = mcfe_pkg::FRAME_LEN;
         mcfe_pkg::POS_ID:     cur_byte = frame_ff.id;
         mcfe_pkg::POS_VAL3:   cur_byte = frame_ff.value[31:24];
         mcfe_pkg::POS_VAL2:   cur_byte = frame_ff.value[23:16];
         mcfe_pkg::POS_VAL1:   cur_byte = frame_ff.value[15:8];
         mcfe_pkg::POS_VAL0:   cur_byte = frame_ff.value[7:0];
         mcfe_pkg::POS_CRC_HI: cur_byte = crc_ff[15:8];
         mcfe_pkg::POS_CRC_LO: cur_byte = crc_ff[7:0];
         mcfe_pkg::POS_STOP:   cur_byte = cfg.stop_byte;
         default:              cur_byte = 8'h00;
      endcase
   end

   // fold id and value bytes into the CRC as they go out
   always_comb begin
      crc_in = crc_ff;
      priority if (advance && pos_ff == mcfe_pkg::POS_ID) begin
         crc_in = mcfe_pkg::crc_feed(16'h0000, cur_byte);
      end else if (advance && pos_ff >= mcfe_pkg::POS_VAL3 && pos_ff <= mcfe_pkg::POS_VAL0) begin
         crc_in = mcfe_pkg::crc_feed(crc_ff, cur_byte);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = mcfe_pkg::POS_START;
      end else if (advance && at_end) begin
         busy_in = 1'b0;
         pos_in  = mcfe_pkg::POS_START;
      end else if (advance) begin
         pos_in  = pos_ff + 4'd1;
      end
      out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= mcfe_pkg::POS_START;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (load) begin
         frame_ff <= cmd;
      end
      if (advance) begin
         out_byte_ff <= cur_byte;
         out_port_ff <= frame_ff.port;
         out_last_ff <= at_end;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.out_port = out_port_ff;
   assign rsp.last     = out_last_ff;
   assign stat.busy    = busy_ff;
   assign stat.pos     = pos_ff;

endmodule

[design/motor_command_frame_encoder.sv]
// Motor command frame encoder. Each accepted command (kind, signed 32-bit value,
// port) is clamped by kind and sent as a ten-byte frame on rsp_chan, one byte per
// transfer: start, length 5, command id, value big-endian, CRC-16 (0x1021, init 0)
// over id and value, stop; last marks the stop byte. Bytes leave at one per cycle
// from the output register while rsp_chan is ready, and the byte serializer holds
// when it is not. An input register and the frame register each buffer one
// command, so the next command is taken while a frame is still going out. The
// first byte passes the input, frame and output registers. Unknown kinds are
// taken and dropped. Write the csr_ registers only while idle.
`include "motor_command_frame_encoder_macros.svh"

module motor_command_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   mcfe_req_if.sink   req_chan,
   mcfe_rsp_if.source rsp_chan
);

   mcfe_pkg::cfg_type  cfg_ff;
   mcfe_pkg::cfg_type  cfg_in;
   mcfe_pkg::cmd_type  cmd;
   logic               cmd_valid;
   logic               cmd_ready;
   mcfe_pkg::stat_type ser_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mcfe_pkg::REG_START:   cfg_in.start_byte = csr_wdata;
            mcfe_pkg::REG_STOP:    cfg_in.stop_byte  = csr_wdata;
            mcfe_pkg::REG_DUTY:    cfg_in.id_duty    = csr_wdata;
            mcfe_pkg::REG_CURRENT: cfg_in.id_current = csr_wdata;
            mcfe_pkg::REG_BRAKE:   cfg_in.id_brake   = csr_wdata;
            mcfe_pkg::REG_SPEED:   cfg_in.id_speed   = csr_wdata;
            mcfe_pkg::REG_ANGLE:   cfg_in.id_angle   = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mcfe_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcfe_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   mcfe_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cfg       (cfg_ff),
      .rsp       (rsp_chan),
      .stat      (ser_stat)
   );

   `MCFE_ASSERT(a_pos_range, 1'b1, ser_stat.pos <= mcfe_pkg::POS_STOP)
   `MCFE_ASSERT(a_idle_pos, !ser_stat.busy, ser_stat.pos == mcfe_pkg::POS_START)
   `MCFE_ASSERT_NEXT(a_load_starts, cmd_valid && cmd_ready, ser_stat.busy && ser_stat.pos == mcfe_pkg::POS_START)
   `MCFE_ASSERT(a_last_at_stop, rsp_chan.valid && rsp_chan.last, ser_stat.pos == mcfe_pkg::POS_START)

endmodule
